[rtl/spb_pkg.sv]
// Package for the sparse pattern builder: sizes, codes and the store port struct.
// No dependencies; used by spb_store and sparse_pattern_builder_unit.
package spb_pkg;

  localparam int MaxNodes     = 1024;
  localparam int MaxPerRow    = 32;
  localparam int MaxElemNodes = 8;

  localparam int NodeW  = $clog2(MaxNodes);
  localparam int SlotW  = $clog2(MaxPerRow);
  localparam int CntW   = $clog2(MaxPerRow + 1);
  localparam int EntAw  = NodeW + SlotW;
  localparam int LimW   = $clog2(MaxNodes + 1);
  localparam int ElemW  = $clog2(MaxElemNodes + 1);
  localparam int ElemIw = $clog2(MaxElemNodes);
  localparam int OffW   = 16;

  typedef enum logic [1:0] {
    ModeAdd   = 2'd0,
    ModeRead  = 2'd1,
    ModeClear = 2'd2,
    ModeNone  = 2'd3
  } mode_e;

  localparam logic RegNodeCount = 1'b0;
  localparam logic RegNodesPerElem = 1'b1;

  typedef struct packed {
    logic             ent_we;
    logic [EntAw-1:0] ent_waddr;
    logic [NodeW-1:0] ent_wdata;
    logic             ent_re;
    logic [EntAw-1:0] ent_raddr;
    logic             cnt_we;
    logic [NodeW-1:0] cnt_waddr;
    logic [CntW-1:0]  cnt_wdata;
    logic             cnt_re;
    logic [NodeW-1:0] cnt_raddr;
  } store_req_t;

endpackage

[rtl/spb_store.sv]
// Row entry memory and row count memory with registered read data.
// Depends on spb_pkg.
module spb_store import spb_pkg::*; (
  input  logic             clk_i,
  input  store_req_t       req_i,
  output logic [NodeW-1:0] ent_rdata_o,
  output logic [CntW-1:0]  cnt_rdata_o
);

  logic [NodeW-1:0] ent_mem [MaxNodes*MaxPerRow];
  logic [CntW-1:0]  cnt_mem [MaxNodes];
  logic [NodeW-1:0] ent_rd_q;
  logic [CntW-1:0]  cnt_rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.ent_we) begin
      ent_mem[req_i.ent_waddr] <= req_i.ent_wdata;
    end
    if (req_i.ent_re) begin
      ent_rd_q <= ent_mem[req_i.ent_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.cnt_we) begin
      cnt_mem[req_i.cnt_waddr] <= req_i.cnt_wdata;
    end
    if (req_i.cnt_re) begin
      cnt_rd_q <= cnt_mem[req_i.cnt_raddr];
    end
  end

  assign ent_rdata_o = ent_rd_q;
  assign cnt_rdata_o = cnt_rd_q;

endmodule

[rtl/sparse_pattern_builder_unit.sv]
// Top level of the sparse pattern builder: sequencer, element buffer and output register.
// Depends on spb_pkg and spb_store.
//
// Usage: the input channel (in_valid_i / in_stall_o) carries one transaction per command:
// add an element, read the next row, or clear the store. The output channel
// (out_valid_o / out_stall_i) carries one transaction per column of a row read, or one
// transaction with has_column low for an empty row.
// All work runs through one compare path and one memory port pair under a small
// sequencer, so the block takes one command at a time and stalls its input meanwhile.
// An add first checks each node against the node count and sorts the element, then
// makes up to 28 inserts; for each insert the walk through the row in the entry memory
// takes most of the time, so an element whose rows are long makes the slowest adds.
// A read passes through SRcnt (row count) and SRld before its first result is registered,
// then yields one result per cycle while the receiver takes them.
// A clear, and every reset, sweeps the row count memory one row per cycle over all
// 1024 rows, during which the input is stalled; configuration writes are taken as ever.
// Results sit in an output register; while the receiver stalls it holds the
// transaction, and the block may already accept the next command. A new result is loaded
// only when the register is empty or being taken.
module sparse_pattern_builder_unit import spb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        mode_i,
  input  logic [NodeW-1:0]  node_0_i,
  input  logic [NodeW-1:0]  node_1_i,
  input  logic [NodeW-1:0]  node_2_i,
  input  logic [NodeW-1:0]  node_3_i,
  input  logic [NodeW-1:0]  node_4_i,
  input  logic [NodeW-1:0]  node_5_i,
  input  logic [NodeW-1:0]  node_6_i,
  input  logic [NodeW-1:0]  node_7_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [NodeW-1:0]  row_o,
  output logic [OffW-1:0]   row_start_o,
  output logic [NodeW-1:0]  column_o,
  output logic              has_column_o,
  output logic              last_in_row_o,
  output logic              overflow_o,
  output logic              range_error_o
);

  typedef enum logic [12:0] {
    SClr  = 13'b0000000000001,
    SIdle = 13'b0000000000010,
    SRchk = 13'b0000000000100,
    SSort = 13'b0000000001000,
    SPair = 13'b0000000010000,
    SCnt  = 13'b0000000100000,
    SSrch = 13'b0000001000000,
    SScmp = 13'b0000010000000,
    SShft = 13'b0000100000000,
    SSmov = 13'b0001000000000,
    SPut  = 13'b0010000000000,
    SRcnt = 13'b0100000000000,
    SRld  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  logic [LimW-1:0]  node_count_q;
  logic [3:0]       npe_q;
  logic [LimW-1:0]  limit;
  logic [ElemW-1:0] used;

  logic [NodeW-1:0] nd_q  [MaxElemNodes];
  logic [NodeW-1:0] loc_q [MaxElemNodes];
  logic [NodeW-1:0] loc_d [MaxElemNodes];
  logic [ElemW-1:0] used_q, nloc_q, nloc_d, j_q, j_d, k_q, k_d;
  logic [CntW-1:0]  idx_q, idx_d, pos_q, pos_d, n_q, n_d;
  logic [NodeW-1:0] ins_r_q, ins_r_d, ins_c_q, ins_c_d;
  logic [NodeW-1:0] clr_q, clr_d;
  logic [NodeW-1:0] rd_row_q, rd_row_d, cur_row_q, cur_row_d;
  logic [OffW-1:0]  rd_off_q, rd_off_d, cur_off_q, cur_off_d;
  logic             ovf_q, ovf_d, rng_q, rng_d;

  logic             out_valid_q, out_valid_d, out_load;
  logic [NodeW-1:0] out_col_q, out_row_q;
  logic [OffW-1:0]  out_off_q;
  logic             out_has_q, out_last_q;
  logic             out_ovf_q, out_rng_q;

  store_req_t       req;
  logic [NodeW-1:0] ent_rdata;
  logic [CntW-1:0]  cnt_rdata;

  logic             accept;
  logic             sort_dup;
  logic [ElemIw:0]  sort_pos;
  logic [NodeW-1:0] sort_v;
  logic             emit_last;

  spb_store u_store (
    .clk_i       (clk_i),
    .req_i       (req),
    .ent_rdata_o (ent_rdata),
    .cnt_rdata_o (cnt_rdata)
  );

  // Configuration port.
  assign pready = 1'b1;
  always_comb begin
    if (paddr[2] == RegNodeCount) begin
      prdata = {{(32-LimW){1'b0}}, node_count_q};
    end else begin
      prdata = {28'd0, npe_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= LimW'(MaxNodes);
      npe_q        <= 4'(MaxElemNodes);
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == RegNodeCount) begin
        node_count_q <= pwdata[LimW-1:0];
      end else begin
        npe_q <= pwdata[3:0];
      end
    end
  end

  // Effective node count and element size after clamping.
  always_comb begin
    if (node_count_q == '0) begin
      limit = LimW'(1);
    end else if (node_count_q > LimW'(MaxNodes)) begin
      limit = LimW'(MaxNodes);
    end else begin
      limit = node_count_q;
    end
    if (npe_q > 4'(MaxElemNodes)) begin
      used = ElemW'(MaxElemNodes);
    end else begin
      used = ElemW'(npe_q);
    end
  end

  assign in_stall_o = (state_q != SIdle);
  assign accept     = in_valid_i && !in_stall_o;

  // Sorted-list insertion of one node: the list is sorted, so the entries below the
  // new value form a prefix and the rest moves up by one place.
  always_comb begin
    sort_v   = nd_q[idx_q[ElemIw-1:0]];
    sort_dup = 1'b0;
    sort_pos = '0;
    for (int p = 0; p < MaxElemNodes; p++) begin
      if (ElemW'(p) < nloc_q) begin
        if (loc_q[p] < sort_v) sort_pos = sort_pos + 1'b1;
        if (loc_q[p] == sort_v) sort_dup = 1'b1;
      end
    end
  end

  assign emit_last = (n_q == '0) || (idx_q + 1'b1 == n_q);
  assign out_load  = (state_q == SRld) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d   = state_q;
    nloc_d    = nloc_q;
    j_d       = j_q;
    k_d       = k_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    n_d       = n_q;
    ins_r_d   = ins_r_q;
    ins_c_d   = ins_c_q;
    clr_d     = clr_q;
    rd_row_d  = rd_row_q;
    rd_off_d  = rd_off_q;
    cur_row_d = cur_row_q;
    cur_off_d = cur_off_q;
    ovf_d     = ovf_q;
    rng_d     = rng_q;
    for (int p = 0; p < MaxElemNodes; p++) loc_d[p] = loc_q[p];
    req       = '0;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      SClr: begin
        req.cnt_we    = 1'b1;
        req.cnt_waddr = clr_q;
        req.cnt_wdata = '0;
        clr_d         = clr_q + 1'b1;
        if (clr_q == NodeW'(MaxNodes - 1)) state_d = SIdle;
      end
      SIdle: begin
        if (accept) begin
          case (mode_i)
            ModeAdd: begin
              idx_d   = '0;
              state_d = SRchk;
            end
            ModeRead: begin
              if (LimW'(rd_row_q) >= limit) begin
                cur_row_d = '0;
                cur_off_d = '0;
              end else begin
                cur_row_d = rd_row_q;
                cur_off_d = rd_off_q;
              end
              req.cnt_re    = 1'b1;
              req.cnt_raddr = cur_row_d;
              state_d       = SRcnt;
            end
            ModeClear: begin
              rd_row_d = '0;
              rd_off_d = '0;
              ovf_d    = 1'b0;
              rng_d    = 1'b0;
              clr_d    = '0;
              state_d  = SClr;
            end
            default: ;
          endcase
        end
      end
      SRchk: begin
        if (ElemW'(idx_q) == used_q) begin
          idx_d   = '0;
          nloc_d  = '0;
          state_d = SSort;
        end else if (LimW'(nd_q[idx_q[ElemIw-1:0]]) >= limit) begin
          rng_d   = 1'b1;
          state_d = SIdle;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      SSort: begin
        if (ElemW'(idx_q) == used_q) begin
          j_d     = '0;
          k_d     = '0;
          state_d = SPair;
        end else begin
          if (!sort_dup) begin
            for (int p = 0; p < MaxElemNodes; p++) begin
              if (ElemW'(p) == ElemW'(sort_pos)) loc_d[p] = sort_v;
              else if ((p > 0) && (ElemW'(p) > ElemW'(sort_pos))) loc_d[p] = loc_q[p-1];
            end
            nloc_d = nloc_q + 1'b1;
          end
          idx_d = idx_q + 1'b1;
        end
      end
      SPair: begin
        // Sorted list: every node below place j is smaller, so column k goes into row j.
        if (j_q >= nloc_q) begin
          state_d = SIdle;
        end else if (k_q >= j_q) begin
          j_d = j_q + 1'b1;
          k_d = '0;
        end else begin
          ins_r_d       = loc_q[j_q[ElemIw-1:0]];
          ins_c_d       = loc_q[k_q[ElemIw-1:0]];
          req.cnt_re    = 1'b1;
          req.cnt_raddr = ins_r_d;
          state_d       = SCnt;
        end
      end
      SCnt: begin
        n_d     = cnt_rdata;
        pos_d   = '0;
        state_d = SSrch;
      end
      SSrch: begin
        if (pos_q == n_q) begin
          if (n_q >= CntW'(MaxPerRow)) begin
            ovf_d   = 1'b1;
            k_d     = k_q + 1'b1;
            state_d = SPair;
          end else begin
            idx_d   = n_q;
            state_d = SShft;
          end
        end else begin
          req.ent_re    = 1'b1;
          req.ent_raddr = {ins_r_q, pos_q[SlotW-1:0]};
          state_d       = SScmp;
        end
      end
      SScmp: begin
        if (ent_rdata < ins_c_q) begin
          pos_d   = pos_q + 1'b1;
          state_d = SSrch;
        end else if (ent_rdata == ins_c_q) begin
          k_d     = k_q + 1'b1;
          state_d = SPair;
        end else if (n_q >= CntW'(MaxPerRow)) begin
          ovf_d   = 1'b1;
          k_d     = k_q + 1'b1;
          state_d = SPair;
        end else begin
          idx_d   = n_q;
          state_d = SShft;
        end
      end
      SShft: begin
        if (idx_q == pos_q) begin
          state_d = SPut;
        end else begin
          req.ent_re    = 1'b1;
          req.ent_raddr = {ins_r_q, SlotW'(idx_q - 1'b1)};
          state_d       = SSmov;
        end
      end
      SSmov: begin
        req.ent_we    = 1'b1;
        req.ent_waddr = {ins_r_q, idx_q[SlotW-1:0]};
        req.ent_wdata = ent_rdata;
        idx_d         = idx_q - 1'b1;
        state_d       = SShft;
      end
      SPut: begin
        req.ent_we    = 1'b1;
        req.ent_waddr = {ins_r_q, pos_q[SlotW-1:0]};
        req.ent_wdata = ins_c_q;
        req.cnt_we    = 1'b1;
        req.cnt_waddr = ins_r_q;
        req.cnt_wdata = n_q + 1'b1;
        k_d           = k_q + 1'b1;
        state_d       = SPair;
      end
      SRcnt: begin
        n_d   = cnt_rdata;
        idx_d = '0;
        if (cnt_rdata != '0) begin
          req.ent_re    = 1'b1;
          req.ent_raddr = {cur_row_q, SlotW'(0)};
        end
        state_d = SRld;
      end
      SRld: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          if (emit_last) begin
            if (LimW'(cur_row_q) + 1'b1 >= limit) begin
              rd_row_d = '0;
              rd_off_d = '0;
            end else begin
              rd_row_d = cur_row_q + 1'b1;
              rd_off_d = cur_off_q + OffW'(n_q);
            end
            state_d = SIdle;
          end else begin
            idx_d         = idx_q + 1'b1;
            req.ent_re    = 1'b1;
            req.ent_raddr = {cur_row_q, SlotW'(idx_q + 1'b1)};
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClr;
      clr_q       <= '0;
      rd_row_q    <= '0;
      rd_off_q    <= '0;
      ovf_q       <= 1'b0;
      rng_q       <= 1'b0;
      out_valid_q <= 1'b0;
      nloc_q      <= '0;
      j_q         <= '0;
      k_q         <= '0;
      idx_q       <= '0;
      pos_q       <= '0;
      n_q         <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rd_row_q    <= rd_row_d;
      rd_off_q    <= rd_off_d;
      ovf_q       <= ovf_d;
      rng_q       <= rng_d;
      out_valid_q <= out_valid_d;
      nloc_q      <= nloc_d;
      j_q         <= j_d;
      k_q         <= k_d;
      idx_q       <= idx_d;
      pos_q       <= pos_d;
      n_q         <= n_d;
    end
  end

  // Payload registers. The sticky flags travel with each result, so a command taken
  // while a result waits cannot change what the receiver sees.
  always_ff @(posedge clk_i) begin
    ins_r_q   <= ins_r_d;
    ins_c_q   <= ins_c_d;
    cur_row_q <= cur_row_d;
    cur_off_q <= cur_off_d;
    for (int p = 0; p < MaxElemNodes; p++) loc_q[p] <= loc_d[p];
    if (accept) begin
      nd_q[0] <= node_0_i;
      nd_q[1] <= node_1_i;
      nd_q[2] <= node_2_i;
      nd_q[3] <= node_3_i;
      nd_q[4] <= node_4_i;
      nd_q[5] <= node_5_i;
      nd_q[6] <= node_6_i;
      nd_q[7] <= node_7_i;
      used_q  <= used;
    end
    if (out_load) begin
      out_row_q  <= cur_row_q;
      out_off_q  <= cur_off_q;
      out_col_q  <= (n_q == '0) ? '0 : ent_rdata;
      out_has_q  <= (n_q != '0);
      out_last_q <= emit_last;
      out_ovf_q  <= ovf_q;
      out_rng_q  <= rng_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign row_o         = out_row_q;
  assign row_start_o   = out_off_q;
  assign column_o      = out_col_q;
  assign has_column_o  = out_has_q;
  assign last_in_row_o = out_last_q;
  assign overflow_o    = out_ovf_q;
  assign range_error_o = out_rng_q;

  // An empty-row result always closes its row.
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_column_o |-> last_in_row_o)
    else $error("empty row result without last_in_row");

  // Entries are only moved up when the row still has room.
  a_shift_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SSmov) |-> (n_q < CntW'(MaxPerRow)) && (idx_q > pos_q))
    else $error("entry move outside the row");

  // A stored column is always below its row.
  a_lower: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SPut) |-> (ins_c_q < ins_r_q))
    else $error("column not below the diagonal");

  // The search position never passes the row count.
  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SSrch || state_q == SScmp) |-> (pos_q <= n_q))
    else $error("search position beyond row count");

endmodule
